// File: rtl/core/sfd_pkg.sv
// shared constants for the small float to double converter
package sfd_pkg;
  localparam int unsigned DblFracW = 52;
  localparam int unsigned DblExpW  = 11;
  localparam int unsigned DblBias  = 1023;
  localparam int unsigned RawW     = 32;
  localparam logic [63:0] DblQnan  = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] DblExpMax = 11'h7FF;
endpackage

// File: rtl/core/small_float_to_double_unit.sv
// top level: packed small float to binary64 converter
// One item per cycle: an item taken with start is held in one input register,
// and its result is then loaded into one result register and shown on the result
// ports with strobe set.
// busy is always low, so start may be held every cycle; the receiver cannot
// stall and must take each result in its strobe cycle.
module small_float_to_double_unit #(
  parameter int unsigned MAX_EXPONENT_BITS = 8,
  parameter int unsigned MAX_MANTISSA_BITS = 23
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] raw_bits,
  input  logic [3:0]  exponent_bits,
  input  logic [4:0]  mantissa_bits,
  input  logic        is_signed,
  output logic        strobe,
  output logic [63:0] double_bits,
  output logic        format_error
);

  logic        in_valid;
  logic [31:0] raw_q;
  logic [3:0]  eb_q;
  logic [4:0]  mb_q;
  logic        sgn_q;

  logic [63:0] double_bits_next;
  logic        format_error_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      raw_q <= raw_bits;
      eb_q  <= exponent_bits;
      mb_q  <= mantissa_bits;
      sgn_q <= is_signed;
    end
  end

  logic [5:0]  width_sum;
  logic        bad;
  logic [31:0] field_shifted;
  logic [9:0]  ef;
  logic [9:0]  emax;
  logic [30:0] mf;
  logic [30:0] mmask;
  logic        sign_bit;
  logic [4:0]  lead;
  logic [12:0] dexp;
  logic [63:0] frac_norm;
  logic [63:0] frac_sub;

  always_comb begin
    width_sum = 6'(eb_q) + 6'(mb_q) + 6'(sgn_q);
    bad = (width_sum > 6'd32) || (eb_q < 4'd2) ||
          (32'(eb_q) > MAX_EXPONENT_BITS) || (mb_q < 5'd1) ||
          (32'(mb_q) > MAX_MANTISSA_BITS);
    emax  = 10'((11'd1 << eb_q) - 11'd1);
    mmask = 31'((32'd1 << mb_q) - 32'd1);
    field_shifted = raw_q >> mb_q;
    ef = field_shifted[9:0] & emax;
    mf = raw_q[30:0] & mmask;
    sign_bit = sgn_q & field_shifted[eb_q];
    // leading-one position of the subnormal mantissa
    lead = '0;
    for (int i = 0; i < 31; i++) begin
      if (mf[i]) lead = 5'(i);
    end
    frac_norm = 64'(mf) << (6'd52 - 6'(mb_q));
    frac_sub  = (64'(mf) & ~(64'd1 << lead)) << (6'd52 - 6'(lead));
    dexp = '0;
    double_bits_next = '0;
    if (ef == emax) begin
      if (mf != '0) double_bits_next = sfd_pkg::DblQnan;
      else double_bits_next = {sign_bit, sfd_pkg::DblExpMax, 52'd0};
    end else if (ef == '0) begin
      if (mf == '0) begin
        double_bits_next = {sign_bit, 63'd0};
      end else begin
        dexp = 13'(lead) - 13'(mb_q) + 13'd1 - 13'(emax >> 1) +
               13'(sfd_pkg::DblBias);
        double_bits_next = {sign_bit, dexp[10:0], frac_sub[51:0]};
      end
    end else begin
      dexp = 13'(ef) - 13'(emax >> 1) + 13'(sfd_pkg::DblBias);
      double_bits_next = {sign_bit, dexp[10:0], frac_norm[51:0]};
    end
    format_error_next = bad;
    if (bad) double_bits_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= in_valid;
    end
    if (in_valid) begin
      double_bits  <= double_bits_next;
      format_error <= format_error_next;
    end
  end

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> strobe) else $error("strobe missing");
  a_start_two: assert property (@(posedge clk) disable iff (rst)
    start |-> ##2 strobe) else $error("latency broken");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && format_error) |-> double_bits == 64'd0) else $error("error not zero");
  a_nan_pos: assert property (@(posedge clk) disable iff (rst)
    (strobe && double_bits[62:52] == sfd_pkg::DblExpMax && double_bits[51:0] != '0)
    |-> !double_bits[63]) else $error("negative nan");

endmodule

// File: tb/testbench.sv
// self-checking testbench for the small float to double converter
`timescale 1ns / 100ps

module testbench;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] raw_bits;
  logic [3:0]  exponent_bits;
  logic [4:0]  mantissa_bits;
  logic        is_signed;
  logic        strobe;
  logic [63:0] double_bits;
  logic        format_error;

  typedef struct packed {
    logic [63:0] bits;
    logic        err;
  } conv_t;

  typedef struct {
    logic [31:0] raw;
    logic [3:0]  eb;
    logic [4:0]  mb;
    logic        sg;
    logic        typed;
    conv_t       want;
  } row_t;

  conv_t pending_q[$];
  int    mismatches = 0;
  int    done_cnt = 0;

  small_float_to_double_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_bits(raw_bits), .exponent_bits(exponent_bits),
    .mantissa_bits(mantissa_bits), .is_signed(is_signed),
    .strobe(strobe), .double_bits(double_bits), .format_error(format_error)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("small_float_to_double_unit regression: fail");
    $finish;
  end

  function automatic conv_t convert(logic [31:0] raw, logic [3:0] eb, logic [4:0] mb,
                                    logic sg);
    conv_t r;
    int unsigned emax, ef, mf, bias, p;
    int dexp;
    logic [63:0] sign, frac;
    r = '0;
    if (int'(eb) + int'(mb) + int'(sg) > 32 || eb < 2 || eb > 8 || mb < 1 || mb > 23) begin
      r.err = 1'b1;
      return r;
    end
    emax = (1 << eb) - 1;
    ef = (raw >> mb) & emax;
    mf = raw & ((1 << mb) - 1);
    bias = emax >> 1;
    sign = (sg && raw[eb + mb]) ? 64'h8000_0000_0000_0000 : 64'd0;
    if (ef == emax) begin
      r.bits = (mf != 0) ? sfd_pkg::DblQnan :
               (sign | {1'b0, sfd_pkg::DblExpMax, 52'd0});
      return r;
    end
    if (ef == 0) begin
      if (mf == 0) begin
        r.bits = sign;
        return r;
      end
      p = 0;
      for (int i = 0; i < mb; i++) if (mf[i]) p = i;
      dexp = int'(p) - int'(mb) + 1 - int'(bias) + int'(sfd_pkg::DblBias);
      frac = (64'(mf) - (64'd1 << p)) << (52 - p);
    end else begin
      dexp = int'(ef) - int'(bias) + int'(sfd_pkg::DblBias);
      frac = 64'(mf) << (52 - mb);
    end
    r.bits = sign | (64'(dexp[10:0]) << 52) | frac;
    return r;
  endfunction

  task automatic report(string what, conv_t got, conv_t want);
    mismatches++;
    $display("mismatch %s: got %h/%b want %h/%b", what, got.bits, got.err,
             want.bits, want.err);
  endtask

  // result checker
  always @(posedge clk) begin
    conv_t got, want;
    if (!rst && strobe) begin
      got.bits = double_bits;
      got.err = format_error;
      if (pending_q.size() == 0) report("unexpected", got, got);
      else begin
        want = pending_q.pop_front();
        if (got.bits !== want.bits) report("double_bits", got, want);
        if (got.err !== want.err) report("format_error", got, want);
      end
      done_cnt++;
    end
  end

  // start is driven with blocking assignments so back-to-back transfers stay legal
  task automatic send(logic [31:0] raw, logic [3:0] eb, logic [4:0] mb, logic sg,
                      bit typed, conv_t want);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    repeat (gap) @(negedge clk);
    raw_bits <= raw; exponent_bits <= eb; mantissa_bits <= mb; is_signed <= sg;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(typed ? want : convert(raw, eb, mb, sg));
    @(negedge clk);
    start = 1'b0;
  endtask

  row_t table_rows[$];

  task automatic add(logic [31:0] raw, logic [3:0] eb, logic [4:0] mb, logic sg,
                     logic typed, logic [63:0] b, logic e);
    row_t r;
    r.raw = raw; r.eb = eb; r.mb = mb; r.sg = sg; r.typed = typed;
    r.want.bits = b; r.want.err = e;
    table_rows.push_back(r);
  endtask

  initial begin
    logic [31:0] raw;
    logic [3:0] eb;
    logic [4:0] mb;
    logic sg;
    start = 0; raw_bits = 0; exponent_bits = 0; mantissa_bits = 0; is_signed = 0;
    rst = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // zero, signed zero, normals, infinities, nan, subnormals, errors, unused high bits
    add(32'h0000_0000, 4'd5, 5'd10, 1'b1, 1, 64'd0, 0);
    add(32'h0000_8000, 4'd5, 5'd10, 1'b1, 1, 64'h8000_0000_0000_0000, 0);
    add(32'h0000_7C00, 4'd5, 5'd10, 1'b1, 1, 64'h7FF0_0000_0000_0000, 0);
    add(32'h0000_FC00, 4'd5, 5'd10, 1'b1, 1, 64'hFFF0_0000_0000_0000, 0);
    add(32'h0000_FC01, 4'd5, 5'd10, 1'b1, 1, sfd_pkg::DblQnan, 0);
    add(32'h0000_FFFF, 4'd5, 5'd10, 1'b0, 1, sfd_pkg::DblQnan, 0);
    add(32'h0000_8000, 4'd5, 5'd10, 1'b0, 1, 64'd0, 0);
    add(32'h0000_3C00, 4'd5, 5'd10, 1'b1, 1, 64'h3FF0_0000_0000_0000, 0);
    add(32'h0000_0001, 4'd5, 5'd10, 1'b1, 0, 0, 0);
    add(32'h0000_03FF, 4'd5, 5'd10, 1'b1, 0, 0, 0);
    add(32'hFFFF_FFFF, 4'd8, 5'd23, 1'b1, 1, sfd_pkg::DblQnan, 0);
    add(32'h7F7F_FFFF, 4'd8, 5'd23, 1'b1, 0, 0, 0);
    add(32'h8000_0001, 4'd8, 5'd23, 1'b1, 0, 0, 0);
    add(32'hFFFF_FFFF, 4'd2, 5'd1, 1'b0, 0, 0, 0);
    add(32'h0000_0005, 4'd2, 5'd1, 1'b1, 0, 0, 0);
    add(32'hFFFF_FFFF, 4'd8, 5'd23, 1'b1, 0, 0, 0);
    add(32'h1234_5678, 4'd8, 5'd24, 1'b1, 1, 64'd0, 1);
    add(32'h1234_5678, 4'd1, 5'd10, 1'b0, 1, 64'd0, 1);
    add(32'h1234_5678, 4'd9, 5'd10, 1'b0, 1, 64'd0, 1);
    add(32'h1234_5678, 4'd15, 5'd31, 1'b1, 1, 64'd0, 1);
    add(32'h1234_5678, 4'd5, 5'd0, 1'b0, 1, 64'd0, 1);
    add(32'hFFFF_FFFF, 4'd0, 5'd0, 1'b0, 1, 64'd0, 1);
    foreach (table_rows[i])
      send(table_rows[i].raw, table_rows[i].eb, table_rows[i].mb, table_rows[i].sg,
           table_rows[i].typed, table_rows[i].want);
    for (int n = 0; n < 1900; n++) begin
      if (n == 950) while (pending_q.size() != 0) @(negedge clk);
      if ($urandom_range(0, 9) == 0) begin
        eb = 4'($urandom); mb = 5'($urandom);
      end else begin
        eb = 4'($urandom_range(2, 8)); mb = 5'($urandom_range(1, 23));
      end
      sg = 1'($urandom);
      raw = $urandom;
      case ($urandom_range(0, 4))
        0: raw = raw & ~(((32'd1 << eb) - 1) << mb);   // subnormal or zero
        1: raw = raw | (((32'd1 << eb) - 1) << mb);    // inf or nan
        2: if ($urandom_range(0, 1)) raw = raw & ~((32'd1 << mb) - 1);
        default: ;
      endcase
      send(raw, eb, mb, sg, 0, '0);
    end
    while (pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("small_float_to_double_unit regression: pass");
    else $display("small_float_to_double_unit regression: fail");
    $finish;
  end
endmodule

// File: files.f
rtl/core/sfd_pkg.sv
rtl/core/small_float_to_double_unit.sv
tb/testbench.sv
